>>> hdl/bpe_pkg.sv
// Shared types and constants for the breakpoint envelope generator.
`timescale 1ns / 1ps
`default_nettype none

package bpe_pkg;

   localparam int PosW      = 16;  // tick position / tick counter
   localparam int LvlW      = 8;   // envelope level
   localparam int SegW      = 4;   // segment / table index
   localparam int CntW      = 5;   // point count register
   localparam int SegSpan   = 16;  // points addressable by a 4-bit index
   localparam int ValW      = 32;  // Q16.16 values
   localparam int ProdW     = 40;  // 8 x 32 product
   localparam int MulDigitW = 8;   // multiplier operand, one bit per cycle
   localparam int MulCntW   = 3;
   localparam int DivNumW   = 24;  // |dpos * rng| < 2^24
   localparam int DivCntW   = 5;
   localparam int ReqDataW  = 32;
   localparam int ReqUserW  = 2;
   localparam int RspDataW  = 40;
   localparam int CsrIdxW   = 3;

   // op codes carried on req_tuser
   localparam logic [1:0] OP_STEP    = 2'd0;
   localparam logic [1:0] OP_LOAD    = 2'd1;
   localparam logic [1:0] OP_RESTART = 2'd2;

   // register indexes
   localparam logic [CsrIdxW-1:0] CSR_POINT_COUNT  = 3'd0;
   localparam logic [CsrIdxW-1:0] CSR_LOOP_FIRST   = 3'd1;
   localparam logic [CsrIdxW-1:0] CSR_LOOP_LAST    = 3'd2;
   localparam logic [CsrIdxW-1:0] CSR_LEVEL_OFFSET = 3'd3;
   localparam logic [CsrIdxW-1:0] CSR_LEVEL_SCALE  = 3'd4;

   typedef struct packed {
      logic [PosW-1:0] pos;
      logic [LvlW-1:0] lvl;
   } point_type;

   typedef struct packed {
      logic            en;
      logic [SegW-1:0] addr;
      point_type       point;
   } tbl_wr_type;

endpackage

`default_nettype wire

>>> hdl/bpe_table.sv
// Point table: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module bpe_table #(
   parameter int DEPTH = 16
) (
   input  wire                        clock,
   input  wire bpe_pkg::tbl_wr_type   wr,
   input  wire [bpe_pkg::CntW-1:0]    rd_addr,
   output bpe_pkg::point_type         rd_data
);

   localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   bpe_pkg::point_type mem_ff [DEPTH];
   bpe_pkg::point_type rd_word_ff;
   logic               rd_ok_ff;

   always_ff @(posedge clock) begin
      if (wr.en && ({1'b0, wr.addr} < bpe_pkg::CntW'(DEPTH))) begin
         mem_ff[wr.addr[AddrW-1:0]] <= wr.point;
      end
   end

   // indexes past the table read as zero
   always_ff @(posedge clock) begin
      rd_ok_ff   <= rd_addr < bpe_pkg::CntW'(DEPTH);
      rd_word_ff <= mem_ff[rd_addr[AddrW-1:0]];
   end

   assign rd_data = rd_ok_ff ? rd_word_ff : '0;

endmodule

`default_nettype wire

>>> hdl/bpe_mul.sv
// Bit-serial multiplier: unsigned 8-bit operand times signed 32-bit operand.
`timescale 1ns / 1ps
`default_nettype none

module bpe_mul (
   input  wire                                    clock,
   input  wire                                    reset,
   input  wire                                    start,
   input  wire [bpe_pkg::MulDigitW-1:0]           mplier,
   input  wire signed [bpe_pkg::ValW-1:0]         mcand,
   output logic                                   done,
   output logic signed [bpe_pkg::ProdW-1:0]       product
);

   logic signed [bpe_pkg::ValW:0]     hi_ff, hi_in, sum;
   logic [bpe_pkg::MulDigitW-1:0]     lo_ff, lo_in;
   logic signed [bpe_pkg::ValW-1:0]   mcand_ff;
   logic [bpe_pkg::MulCntW-1:0]       cnt_ff;
   logic                              busy_ff;
   logic                              done_ff;

   // add on the low bit, then shift the pair right one place
   always_comb begin
      sum   = hi_ff + (lo_ff[0] ? {mcand_ff[bpe_pkg::ValW-1], mcand_ff} : '0);
      hi_in = {sum[bpe_pkg::ValW], sum[bpe_pkg::ValW:1]};
      lo_in = {sum[0], lo_ff[bpe_pkg::MulDigitW-1:1]};
   end

   always_ff @(posedge clock) begin
      if (start) begin
         hi_ff    <= '0;
         lo_ff    <= mplier;
         mcand_ff <= mcand;
      end else if (busy_ff) begin
         hi_ff <= hi_in;
         lo_ff <= lo_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= busy_ff && (cnt_ff == '0);
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= bpe_pkg::MulCntW'(bpe_pkg::MulDigitW - 1);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   assign done    = done_ff;
   assign product = {hi_ff[bpe_pkg::ValW-1:0], lo_ff};

endmodule

`default_nettype wire

>>> hdl/bpe_div.sv
// Restoring divider, one quotient bit per cycle, 24-bit by 16-bit unsigned.
`timescale 1ns / 1ps
`default_nettype none

module bpe_div (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          start,
   input  wire [bpe_pkg::DivNumW-1:0]   dividend,
   input  wire [bpe_pkg::PosW-1:0]      divisor,
   output logic                         done,
   output logic [bpe_pkg::DivNumW-1:0]  quotient
);

   logic [bpe_pkg::PosW-1:0]    rem_ff, rem_in, den_ff;
   logic [bpe_pkg::DivNumW-1:0] quo_ff, quo_in;
   logic [bpe_pkg::PosW:0]      trial, diff;
   logic                        ge;
   logic [bpe_pkg::DivCntW-1:0] cnt_ff;
   logic                        busy_ff;
   logic                        done_ff;

   // dividend shifts out the top of quo_ff as quotient bits shift in
   always_comb begin
      trial  = {rem_ff, quo_ff[bpe_pkg::DivNumW-1]};
      diff   = trial - {1'b0, den_ff};
      ge     = trial >= {1'b0, den_ff};
      rem_in = ge ? diff[bpe_pkg::PosW-1:0] : trial[bpe_pkg::PosW-1:0];
      quo_in = {quo_ff[bpe_pkg::DivNumW-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
         den_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= busy_ff && (cnt_ff == '0);
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= bpe_pkg::DivCntW'(bpe_pkg::DivNumW - 1);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

>>> hdl/breakpoint_envelope_generator.sv
// Top level of the breakpoint envelope generator: sequencer, registers, output stage.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake               Payload
// req_      in         req_tvalid/req_tready   tuser op, tdata point and sustain fields
// rsp_      out        rsp_tvalid/rsp_tready   tdata level and scaled value
// csr_      in         csr_valid/csr_ready     csr_index, csr_data
//
// A step item takes four table reads and then, when the level is interpolated,
// a serial multiply, a serial divide and a second serial multiply for the Q16.16
// value, each unit flagging done through a register; when the point level is used
// directly only the second multiply follows the reads. Load and restart items
// complete in the idle state, and a new item is taken only there. The divider produces one quotient bit per cycle.
// Reset is synchronous and active high; the point table is not cleared.
// A finished result waits in the output register; while it is not taken the
// next step item runs up to its final cycle and holds there.

module breakpoint_envelope_generator #(
   parameter int MAX_POINTS = 16
) (
   input  wire                              clock,
   input  wire                              reset,
   // req channel
   input  wire                              req_tvalid,
   output logic                             req_tready,
   // [0] sustain_held, [4:1] point_index, [20:5] point_position,
   // [28:21] point_level, [31:29] zero
   input  wire [bpe_pkg::ReqDataW-1:0]      req_tdata,
   // [1:0] op
   input  wire [bpe_pkg::ReqUserW-1:0]      req_tuser,
   // rsp channel
   output logic                             rsp_tvalid,
   input  wire                              rsp_tready,
   // [7:0] level, [39:8] scaled_value
   output logic [bpe_pkg::RspDataW-1:0]     rsp_tdata,
   // configuration write channel
   input  wire                              csr_valid,
   output logic                             csr_ready,
   input  wire [bpe_pkg::CsrIdxW-1:0]       csr_index,
   input  wire [bpe_pkg::ValW-1:0]          csr_data
);

   // points actually stored: a 4-bit index reaches no further than SegSpan
   localparam int Depth = (MAX_POINTS < bpe_pkg::SegSpan) ? MAX_POINTS : bpe_pkg::SegSpan;

   localparam logic [3:0] ST_IDLE    = 4'd0;
   localparam logic [3:0] ST_RD_SEG  = 4'd1;
   localparam logic [3:0] ST_RD_NXT  = 4'd2;
   localparam logic [3:0] ST_RD_LF   = 4'd3;
   localparam logic [3:0] ST_RD_LF1  = 4'd4;
   localparam logic [3:0] ST_MUL_RNG = 4'd5;
   localparam logic [3:0] ST_DIV     = 4'd6;
   localparam logic [3:0] ST_MUL_SCL = 4'd7;
   localparam logic [3:0] ST_OUT     = 4'd8;

   // ---------------- input item fields ----------------
   logic [1:0]                  req_op;
   logic                        req_sus;
   logic [bpe_pkg::SegW-1:0]    req_idx;
   logic [bpe_pkg::PosW-1:0]    req_pos;
   logic [bpe_pkg::LvlW-1:0]    req_lvl;

   assign req_op  = req_tuser[1:0];
   assign req_sus = req_tdata[0];
   assign req_idx = req_tdata[4:1];
   assign req_pos = req_tdata[20:5];
   assign req_lvl = req_tdata[28:21];

   // ---------------- configuration registers ----------------
   logic [bpe_pkg::CntW-1:0]          point_count_ff;
   logic [bpe_pkg::SegW-1:0]          loop_first_ff;
   logic [bpe_pkg::SegW-1:0]          loop_last_ff;
   logic signed [bpe_pkg::ValW-1:0]   level_offset_ff;
   logic signed [bpe_pkg::ValW-1:0]   level_scale_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         point_count_ff  <= bpe_pkg::CntW'(1);
         loop_first_ff   <= '0;
         loop_last_ff    <= '0;
         level_offset_ff <= '0;
         level_scale_ff  <= bpe_pkg::ValW'(65536);
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            bpe_pkg::CSR_POINT_COUNT:  point_count_ff  <= csr_data[bpe_pkg::CntW-1:0];
            bpe_pkg::CSR_LOOP_FIRST:   loop_first_ff   <= csr_data[bpe_pkg::SegW-1:0];
            bpe_pkg::CSR_LOOP_LAST:    loop_last_ff    <= csr_data[bpe_pkg::SegW-1:0];
            bpe_pkg::CSR_LEVEL_OFFSET: level_offset_ff <= csr_data;
            bpe_pkg::CSR_LEVEL_SCALE:  level_scale_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // points in use, clamped to 1..Depth
   logic [bpe_pkg::CntW-1:0] cnt_used;
   always_comb begin
      if (point_count_ff == '0) begin
         cnt_used = bpe_pkg::CntW'(1);
      end else if (point_count_ff > bpe_pkg::CntW'(Depth)) begin
         cnt_used = bpe_pkg::CntW'(Depth);
      end else begin
         cnt_used = point_count_ff;
      end
   end

   // ---------------- state ----------------
   logic [3:0]                  state_ff, state_in;
   logic [bpe_pkg::SegW-1:0]    seg_ff, seg_in;
   logic [bpe_pkg::PosW-1:0]    tick_ff, tick_in;
   logic                        sus_ff;
   logic [bpe_pkg::PosW-1:0]    p0_ff, p1_ff, plf_ff, plf1_ff;
   logic [bpe_pkg::LvlW-1:0]    l0_ff, l1_ff, lv_ff, lv_in;
   logic                        rsp_valid_ff;
   logic [bpe_pkg::RspDataW-1:0] rsp_data_ff;

   logic req_fire;
   logic out_load;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_load   = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_tready);

   // ---------------- point table ----------------
   bpe_pkg::tbl_wr_type       tbl_wr;
   bpe_pkg::point_type        tbl_rd;
   logic [bpe_pkg::CntW-1:0]  tbl_addr;
   logic [bpe_pkg::CntW-1:0]  seg_nxt, lf_nxt;

   assign seg_nxt = {1'b0, seg_ff} + 1'b1;
   assign lf_nxt  = {1'b0, loop_first_ff} + 1'b1;

   always_comb begin
      tbl_wr.en        = req_fire && (req_op == bpe_pkg::OP_LOAD);
      tbl_wr.addr      = req_idx;
      tbl_wr.point.pos = req_pos;
      tbl_wr.point.lvl = req_lvl;
   end

   // read address for the word that arrives in the following state
   always_comb begin
      case (state_ff)
         ST_RD_SEG: tbl_addr = seg_nxt;
         ST_RD_NXT: tbl_addr = {1'b0, loop_first_ff};
         ST_RD_LF:  tbl_addr = lf_nxt;
         default:   tbl_addr = {1'b0, seg_ff};
      endcase
   end

   bpe_table #(
      .DEPTH (Depth)
   ) u_table (
      .clock   (clock),
      .wr      (tbl_wr),
      .rd_addr (tbl_addr),
      .rd_data (tbl_rd)
   );

   // ---------------- interpolation terms ----------------
   logic                        interp;
   logic                        rng_neg;
   logic [bpe_pkg::LvlW-1:0]    rng_mag;
   logic [bpe_pkg::PosW-1:0]    dpos, dur;

   always_comb begin
      interp  = (tick_ff > p0_ff) && (seg_nxt < cnt_used) && (p1_ff > p0_ff);
      rng_neg = l1_ff < l0_ff;
      rng_mag = rng_neg ? (l0_ff - l1_ff) : (l1_ff - l0_ff);
      dpos    = tick_ff - p0_ff;
      dur     = p1_ff - p0_ff;
   end

   // ---------------- serial arithmetic units ----------------
   logic                                 mul_start, mul_done;
   logic [bpe_pkg::MulDigitW-1:0]        mul_mplier;
   logic signed [bpe_pkg::ValW-1:0]      mul_mcand;
   logic signed [bpe_pkg::ProdW-1:0]     mul_product;
   logic                                 div_start, div_done;
   logic [bpe_pkg::DivNumW-1:0]          div_quotient;
   logic [bpe_pkg::LvlW-1:0]             lv_div;
   logic [bpe_pkg::DivNumW:0]            lv_sum;

   // level from the quotient, sign restored, clamped to 0..255
   always_comb begin
      lv_sum = {1'b0, div_quotient} + (bpe_pkg::DivNumW + 1)'(l0_ff);
      if (rng_neg) begin
         lv_div = (div_quotient > bpe_pkg::DivNumW'(l0_ff)) ? '0 :
                  (l0_ff - div_quotient[bpe_pkg::LvlW-1:0]);
      end else begin
         lv_div = (lv_sum > (bpe_pkg::DivNumW + 1)'(255)) ? bpe_pkg::LvlW'(255) :
                  lv_sum[bpe_pkg::LvlW-1:0];
      end
   end

   // first multiply is dpos * |rng|, second is level * scale
   always_comb begin
      mul_start  = 1'b0;
      mul_mplier = l0_ff;
      mul_mcand  = level_scale_ff;
      if (state_ff == ST_RD_LF1) begin
         mul_start = 1'b1;
         if (interp) begin
            mul_mplier = rng_mag;
            mul_mcand  = {{(bpe_pkg::ValW - bpe_pkg::PosW){1'b0}}, dpos};
         end
      end else if ((state_ff == ST_DIV) && div_done) begin
         mul_start  = 1'b1;
         mul_mplier = lv_div;
      end
   end

   assign div_start = (state_ff == ST_MUL_RNG) && mul_done;

   bpe_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .mplier  (mul_mplier),
      .mcand   (mul_mcand),
      .done    (mul_done),
      .product (mul_product)
   );

   bpe_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (mul_product[bpe_pkg::DivNumW-1:0]),
      .divisor  (dur),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // ---------------- scaled value, saturated ----------------
   logic signed [bpe_pkg::ProdW:0]   sv_sum;
   logic [bpe_pkg::ValW-1:0]         sv_sat;

   always_comb begin
      sv_sum = {{(bpe_pkg::ProdW + 1 - bpe_pkg::ValW){level_offset_ff[bpe_pkg::ValW-1]}},
                level_offset_ff}
             + {mul_product[bpe_pkg::ProdW-1], mul_product};
      if ((sv_sum[bpe_pkg::ProdW:bpe_pkg::ValW-1] == '0) ||
          (sv_sum[bpe_pkg::ProdW:bpe_pkg::ValW-1] == '1)) begin
         sv_sat = sv_sum[bpe_pkg::ValW-1:0];
      end else if (sv_sum[bpe_pkg::ProdW]) begin
         sv_sat = {1'b1, {(bpe_pkg::ValW - 1){1'b0}}};
      end else begin
         sv_sat = {1'b0, {(bpe_pkg::ValW - 1){1'b1}}};
      end
   end

   // ---------------- tick advance and sustain loop ----------------
   logic                        loop_case;
   logic [bpe_pkg::PosW-1:0]    tick_adv, tick_lf;
   logic [bpe_pkg::SegW-1:0]    seg_adv;

   always_comb begin
      loop_case = sus_ff && (seg_ff >= loop_last_ff);
      seg_adv   = seg_ff;
      tick_adv  = tick_ff;
      tick_lf   = plf_ff + 1'b1;
      if (!loop_case) begin
         if (seg_nxt < cnt_used) begin
            tick_adv = tick_ff + 1'b1;
            if (tick_adv == p1_ff) begin
               seg_adv = seg_nxt[bpe_pkg::SegW-1:0];
            end
         end
      end else if (seg_ff != loop_first_ff) begin
         // jump back to the loop start, then, if it lies before the loop end, take one normal step
         seg_adv  = loop_first_ff;
         tick_adv = plf_ff;
         if ((loop_first_ff < loop_last_ff) && (lf_nxt < cnt_used)) begin
            tick_adv = tick_lf;
            if (tick_lf == plf1_ff) begin
               seg_adv = lf_nxt[bpe_pkg::SegW-1:0];
            end
         end
      end
   end

   // ---------------- sequencer ----------------
   always_comb begin
      state_in = state_ff;
      seg_in   = seg_ff;
      tick_in  = tick_ff;
      lv_in    = lv_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (req_op)
                  bpe_pkg::OP_STEP: state_in = ST_RD_SEG;
                  bpe_pkg::OP_RESTART: begin
                     seg_in  = '0;
                     tick_in = '0;
                  end
                  default: ;
               endcase
            end
         end
         ST_RD_SEG: state_in = ST_RD_NXT;
         ST_RD_NXT: state_in = ST_RD_LF;
         ST_RD_LF:  state_in = ST_RD_LF1;
         ST_RD_LF1: begin
            lv_in    = l0_ff;
            state_in = interp ? ST_MUL_RNG : ST_MUL_SCL;
         end
         ST_MUL_RNG: begin
            if (mul_done) begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               lv_in    = lv_div;
               state_in = ST_MUL_SCL;
            end
         end
         ST_MUL_SCL: begin
            if (mul_done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (out_load) begin
               seg_in   = seg_adv;
               tick_in  = tick_adv;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         seg_ff   <= '0;
         tick_ff  <= '0;
      end else begin
         state_ff <= state_in;
         seg_ff   <= seg_in;
         tick_ff  <= tick_in;
      end
   end

   // operand capture
   always_ff @(posedge clock) begin
      lv_ff <= lv_in;
      if (req_fire) begin
         sus_ff <= req_sus;
      end
      case (state_ff)
         ST_RD_SEG: begin
            p0_ff <= tbl_rd.pos;
            l0_ff <= tbl_rd.lvl;
         end
         ST_RD_NXT: begin
            p1_ff <= tbl_rd.pos;
            l1_ff <= tbl_rd.lvl;
         end
         ST_RD_LF:  plf_ff  <= tbl_rd.pos;
         ST_RD_LF1: plf1_ff <= tbl_rd.pos;
         default: ;
      endcase
   end

   // ---------------- output register ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_data_ff <= {sv_sat, lv_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

>>> sim/breakpoint_envelope_generator_tb.sv
// Self-checking testbench for the breakpoint envelope generator.
`timescale 1ns / 1ps

module breakpoint_envelope_generator_tb;
   import bpe_pkg::*;

   localparam int NumPoints    = 16;
   localparam int ClockPeriod  = 10;
   localparam int ResetCycles  = 7;
   localparam int SettleCycles = 64;
   localparam int QuietLimit   = 2000;  // cycles with no handshake on any channel
   localparam int MaxGap       = 18;
   localparam int PhaseCount   = 14;
   localparam int PhaseItems   = 105;
   localparam int MaxReports   = 40;

   // op code the block ignores
   localparam logic [ReqUserW-1:0] OpUnused = 2'd3;

   localparam logic [ValW-1:0] Q16MinBits = 32'h8000_0000;
   localparam logic [ValW-1:0] Q16MaxBits = 32'h7FFF_FFFF;
   localparam logic [ValW-1:0] Q16One     = 32'h0001_0000;
   localparam longint Q16Max = 64'sd2147483647;
   localparam longint Q16Min = -64'sd2147483648;

   typedef struct packed {
      logic [LvlW-1:0] level;
      logic [ValW-1:0] scaled;
   } env_level_t;

   // Envelope predictor plus the queue of levels still owed by the block.
   class envelope_scoreboard;
      logic [CntW-1:0]        point_count;
      logic [SegW-1:0]        loop_first;
      logic [SegW-1:0]        loop_last;
      logic signed [ValW-1:0] level_offset;
      logic signed [ValW-1:0] level_scale;
      logic [SegW-1:0]        segment;
      logic [PosW-1:0]        tick;
      logic [PosW-1:0]        pos_tbl [NumPoints];
      logic [LvlW-1:0]        lvl_tbl [NumPoints];
      env_level_t             pending_levels [$];
      int                     mismatches;

      function new();
         point_count  = 1;
         loop_first   = '0;
         loop_last    = '0;
         level_offset = '0;
         level_scale  = Q16One;
         segment      = '0;
         tick         = '0;
         mismatches   = 0;
      endfunction

      function void write_reg(logic [CsrIdxW-1:0] index, logic [ValW-1:0] value);
         case (index)
            CSR_POINT_COUNT:  point_count  = value[CntW-1:0];
            CSR_LOOP_FIRST:   loop_first   = value[SegW-1:0];
            CSR_LOOP_LAST:    loop_last    = value[SegW-1:0];
            CSR_LEVEL_OFFSET: level_offset = value;
            CSR_LEVEL_SCALE:  level_scale  = value;
            default: ;
         endcase
      endfunction

      // Advance the envelope by one accepted item; a step queues its level.
      function void track_item(logic [ReqUserW-1:0] op, logic [ReqDataW-1:0] data);
         logic            held;
         logic [SegW-1:0] seg;
         logic [PosW-1:0] tk;
         int              used;
         int              nxt;
         int              p1;
         int              dur;
         int              lv;
         longint          sv;
         bit              done;
         env_level_t      want;
         held = data[0];
         if (op == OP_LOAD) begin
            pos_tbl[data[4:1]] = data[20:5];
            lvl_tbl[data[4:1]] = data[28:21];
         end else if (op == OP_RESTART) begin
            segment = '0;
            tick    = '0;
         end else if (op == OP_STEP) begin
            used = (point_count == 0) ? 1 :
                   (point_count > NumPoints) ? NumPoints : int'(point_count);
            seg  = segment;
            tk   = tick;
            lv   = lvl_tbl[seg];
            nxt  = seg + 1;
            // between points: truncating interpolation, clamped to a level
            if (tk > pos_tbl[seg] && nxt < used) begin
               p1  = pos_tbl[seg];
               dur = int'(pos_tbl[nxt]) - p1;
               if (dur > 0) begin
                  lv = lv + ((int'(tk) - p1) * (int'(lvl_tbl[nxt]) - lv)) / dur;
                  if (lv < 0) lv = 0;
                  if (lv > 255) lv = 255;
               end
            end
            sv = longint'(level_offset) + longint'(lv) * longint'(level_scale);
            if (sv > Q16Max) sv = Q16Max;
            if (sv < Q16Min) sv = Q16Min;
            // tick advance, or jump back while the note is held at or past the loop end
            done = 1'b0;
            for (int pass = 0; pass < 3 && !done; pass++) begin
               if (!held || seg < loop_last) begin
                  nxt = seg + 1;
                  if (nxt < used) begin
                     tk = tk + 1'b1;
                     if (tk == pos_tbl[nxt]) seg = seg + 1'b1;
                  end
                  done = 1'b1;
               end else if (seg == loop_first) begin
                  done = 1'b1;
               end else begin
                  seg = loop_first;
                  tk  = pos_tbl[seg];
               end
            end
            segment     = seg;
            tick        = tk;
            want.level  = lv[LvlW-1:0];
            want.scaled = sv[ValW-1:0];
            pending_levels.push_back(want);
         end
      endfunction

      task report_mismatch(string what, logic [ValW-1:0] got, logic [ValW-1:0] want);
         mismatches++;
         if (mismatches <= MaxReports)
            $display("%0t ns: %s mismatch, got %0h expected %0h", $time, what, got, want);
      endtask

      task check_level(logic [RspDataW-1:0] data);
         env_level_t want;
         if (pending_levels.size() == 0) begin
            report_mismatch("unrequested level", ValW'(data[LvlW-1:0]), '0);
         end else begin
            want = pending_levels.pop_front();
            if (data[LvlW-1:0] !== want.level)
               report_mismatch("level", ValW'(data[LvlW-1:0]), ValW'(want.level));
            if (data[RspDataW-1:LvlW] !== want.scaled)
               report_mismatch("scaled_value", data[RspDataW-1:LvlW], want.scaled);
         end
      endtask

      function int pending();
         return pending_levels.size();
      endfunction
   endclass

   logic                clock;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [ReqDataW-1:0] req_tdata = '0;   // [0] sustain_held, [4:1] point_index,
                                          // [20:5] point_position, [28:21] point_level
   logic [ReqUserW-1:0] req_tuser = '0;   // [1:0] op
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [RspDataW-1:0] rsp_tdata;        // [7:0] level, [39:8] scaled_value
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [CsrIdxW-1:0]  csr_index = '0;
   logic [ValW-1:0]     csr_data = '0;

   envelope_scoreboard envelope_sb = new();

   int items_sent = 0;        // load, step and restart items accepted
   bit req_steady = 1'b0;     // no gaps on the item side
   bit rsp_steady = 1'b0;     // no stalls on the result side
   logic [SegW-1:0] cfg_first = '0;

   breakpoint_envelope_generator #(.MAX_POINTS(NumPoints)) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #(ClockPeriod / 2) clock = ~clock;
   end

   // All handshakes are observed here, on pre-edge values, in a fixed order.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) envelope_sb.write_reg(csr_index, csr_data);
         if (req_tvalid && req_tready) envelope_sb.track_item(req_tuser, req_tdata);
         if (rsp_tvalid && rsp_tready) envelope_sb.check_level(rsp_tdata);
      end
   end

   function automatic int draw_gap(bit steady);
      return steady ? 0 : $urandom_range(0, MaxGap);
   endfunction

   // Result side: a fresh random stall before every item taken, none when steady.
   initial begin : rsp_side
      int stall;
      while (reset) @(posedge clock);
      forever begin
         stall = draw_gap(rsp_steady);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   // Ends the run if the block stops moving items on every channel.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QuietLimit) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("TB_ERROR");
      $finish;
   end

   // valid stays up across back-to-back items; it only drops for a gap
   task automatic send_item(logic [ReqUserW-1:0] op, logic held, logic [SegW-1:0] index,
                            logic [PosW-1:0] position, logic [LvlW-1:0] lvl);
      int gap;
      gap = draw_gap(req_steady);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {3'b000, lvl, position, index, held};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (op != OpUnused) items_sent++;
   endtask

   task automatic write_reg(logic [CsrIdxW-1:0] index, logic [ValW-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   // Drain owed levels, then let a load or restart in flight finish.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (envelope_sb.pending() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic configure(logic [CntW-1:0] count, logic [SegW-1:0] sustain_first,
                            logic [SegW-1:0] sustain_last, logic [ValW-1:0] offset,
                            logic [ValW-1:0] scale);
      wait_idle();
      write_reg(CSR_POINT_COUNT, ValW'(count));
      write_reg(CSR_LOOP_FIRST, ValW'(sustain_first));
      write_reg(CSR_LOOP_LAST, ValW'(sustain_last));
      write_reg(CSR_LEVEL_OFFSET, offset);
      write_reg(CSR_LEVEL_SCALE, scale);
      csr_valid <= 1'b0;
      cfg_first = sustain_first;
   endtask

   // Q16.16 pick biased to the saturating extremes and to small values
   function automatic logic [ValW-1:0] pick_q16();
      case ($urandom_range(0, 4))
         0: return Q16MinBits;
         1: return Q16MaxBits;
         2: return '0;
         3: return ValW'($urandom_range(0, 32'h0003_FFFF)) - 32'h0002_0000;
         default: return ValW'($urandom());
      endcase
   endfunction

   initial begin : stimulus
      int              phase;
      int              i;
      int              kind;
      int              run;
      int              release_at;
      int              budget;
      int              n_points;
      int              sus_first;
      int              sus_last;
      int              wrap_from;
      int              r;
      logic [PosW-1:0] next_pos;
      logic [LvlW-1:0] lvl_pick;

      repeat (ResetCycles) @(posedge clock);
      reset <= 1'b0;

      // ---- directed part ------------------------------------------------
      // four points in use, sustain loop over points 1..2
      configure(5'd4, 4'd1, 4'd2, '0, Q16One);
      // every table entry written first; last one at the top of both ranges
      for (i = 0; i < NumPoints; i++)
         send_item(OP_LOAD, i[0], SegW'(i),
                   (i == NumPoints - 1) ? 16'hFFFF : PosW'(3 * i), i[0] ? 8'hFF : 8'h00);
      // held note rises to point 1, falls to point 2 and jumps back
      repeat (8) send_item(OP_STEP, 1'b1, '0, '0, '0);
      send_item(OpUnused, 1'b1, '1, '1, '1);      // ignored, no level
      send_item(OP_RESTART, 1'b0, '0, '0, '0);
      repeat (2) send_item(OP_STEP, 1'b0, '1, '1, '1);
      // next point moved behind the tick: extrapolation clamps at full level
      send_item(OP_LOAD, 1'b0, 4'd1, 16'd1, 8'hFF);
      repeat (2) send_item(OP_STEP, 1'b0, '0, '0, '0);
      // next point at the current position: current level comes out
      send_item(OP_LOAD, 1'b0, 4'd1, 16'd0, 8'hFF);
      send_item(OP_STEP, 1'b0, '0, '0, '0);
      // falling slope past its end clamps at zero
      send_item(OP_LOAD, 1'b0, 4'd0, 16'd0, 8'hFF);
      send_item(OP_LOAD, 1'b0, 4'd1, 16'd1, 8'h00);
      send_item(OP_STEP, 1'b0, '0, '0, '0);
      send_item(OP_LOAD, 1'b0, 4'd0, 16'd0, 8'h00);
      send_item(OP_LOAD, 1'b0, 4'd1, 16'd3, 8'hFF);
      send_item(OP_RESTART, 1'b1, '1, '1, '1);
      repeat (4) send_item(OP_STEP, 1'b0, '0, '0, '0);

      // ---- random phases ------------------------------------------------
      for (phase = 1; phase < PhaseCount; phase++) begin
         case (phase)
            // full table, loop over everything, saturating Q16.16 extremes
            1: configure(5'd16, 4'd0, 4'd15, Q16MinBits, Q16MaxBits);
            // single point: the envelope holds at point 0
            2: configure(5'd1, 4'd0, 4'd0, Q16MaxBits, Q16MinBits);
            // loop start beyond loop end; the jump target may sit near tick wrap
            3: configure(5'd12, 4'd9, 4'd2, '0, 32'hFFFF_FFFF);
            // count zero acts as one point; zero scale
            4: configure(5'd0, 4'd15, 4'd15, pick_q16(), '0);
            // count above the table is capped
            5: configure(5'd31, 4'd3, 4'd14, pick_q16(), pick_q16());
            default: begin
               n_points  = $urandom_range(2, NumPoints);
               sus_first = $urandom_range(0, n_points - 1);
               sus_last  = $urandom_range(sus_first, n_points - 1);
               if ($urandom_range(0, 3) == 0) begin
                  sus_first = $urandom_range(0, 15);
                  sus_last  = $urandom_range(0, 15);
               end
               configure(CntW'(n_points), SegW'(sus_first), SegW'(sus_last),
                         pick_q16(), pick_q16());
            end
         endcase
         rsp_steady = ($urandom_range(0, 3) == 0);
         budget = items_sent + PhaseItems;
         while (items_sent < budget) begin
            kind = $urandom_range(0, 9);
            req_steady = ($urandom_range(0, 5) == 0);
            if (kind < 7) begin
               // well-formed: fresh table rising mod 2^16, restart, a note held then released
               next_pos  = PosW'($urandom_range(0, 3));
               wrap_from = ($urandom_range(0, 2) == 0) ? int'(cfg_first) : NumPoints;
               for (i = 0; i < NumPoints; i++) begin
                  if (i == wrap_from) next_pos = 16'hFFFF - PosW'($urandom_range(0, 2));
                  r = $urandom_range(0, 5);
                  lvl_pick = (r == 0) ? 8'h00 : (r == 1) ? 8'hFF : LvlW'($urandom());
                  send_item(OP_LOAD, 1'($urandom_range(0, 1)), SegW'(i), next_pos, lvl_pick);
                  next_pos = next_pos + (($urandom_range(0, 7) == 0) ?
                             PosW'($urandom_range(7, 40)) : PosW'($urandom_range(1, 6)));
               end
               send_item(OP_RESTART, 1'($urandom_range(0, 1)), SegW'($urandom()),
                         PosW'($urandom()), LvlW'($urandom()));
               run = $urandom_range(8, 60);
               release_at = $urandom_range(0, run);
               for (i = 0; i < run; i++)
                  send_item(OP_STEP, i < release_at, SegW'($urandom()),
                            PosW'($urandom()), LvlW'($urandom()));
            end else if (kind < 9) begin
               // noise: any op, any field, including loads that break the order
               run = $urandom_range(1, 6);
               for (i = 0; i < run; i++)
                  send_item(ReqUserW'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                            SegW'($urandom()),
                            $urandom_range(0, 1) ? PosW'($urandom()) :
                                                   PosW'($urandom_range(0, 60)),
                            LvlW'($urandom()));
            end else begin
               // restart with the sustain flag drawn at random on every step
               send_item(OP_RESTART, 1'b0, '0, '0, '0);
               run = $urandom_range(4, 20);
               for (i = 0; i < run; i++)
                  send_item(OP_STEP, 1'($urandom_range(0, 1)), '0, '0, '0);
            end
         end
      end

      wait_idle();
      if (envelope_sb.mismatches == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
